/* hdl/rlps_pkg.sv */
`default_nettype none

package rlps_pkg;

    // chain capacity and the widths that follow from it
    localparam int MAX_LEDS = 1024;
    localparam int IDX_W    = $clog2(MAX_LEDS);
    localparam int POS_W    = $clog2(MAX_LEDS + 1);

    // fixed field widths
    localparam int BYTE_W      = 8;
    localparam int COLOR_W     = 3 * BYTE_W;
    localparam int LED_INDEX_W = 10;
    localparam int COUNT_W     = 11;
    localparam int GAP_W       = 12;
    localparam int SHIFT_W     = 3;
    localparam int BIT_W       = 5;
    localparam int BITS_PER_LED = 24;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH_TIME  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_SLOTS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SHIFT      = 3'd4;

    localparam logic [BYTE_W-1:0]  RST_ZERO_HIGH_TIME = 8'd8;
    localparam logic [BYTE_W-1:0]  RST_ONE_HIGH_TIME  = 8'd16;
    localparam int                 RST_LED_COUNT      = 64;
    localparam logic [GAP_W-1:0]   RST_RESET_SLOTS    = 12'd40;
    localparam logic [SHIFT_W-1:0] RST_DIM_SHIFT      = 3'd2;

    // item opcodes
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0]  zero_high;
        logic [BYTE_W-1:0]  one_high;
        logic [POS_W-1:0]   eff_count;
        logic [GAP_W-1:0]   gap_len;
        logic [SHIFT_W-1:0] dim_shift;
    } t_cfg;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [COLOR_W-1:0] wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } t_mem_req;

    typedef struct packed {
        logic             valid;
        logic             gap;
        logic             last;
        logic [BIT_W-1:0] sh;
    } t_slot;

endpackage

`default_nettype wire

/* hdl/rlps_if.sv */
`default_nettype none

interface rlps_item_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic [rlps_pkg::LED_INDEX_W-1:0]    led_index;
    logic [rlps_pkg::BYTE_W-1:0]         first_byte;
    logic [rlps_pkg::BYTE_W-1:0]         second_byte;
    logic [rlps_pkg::BYTE_W-1:0]         third_byte;

    modport source (output valid, op, led_index, first_byte, second_byte, third_byte,
                    input ready);
    modport sink   (input valid, op, led_index, first_byte, second_byte, third_byte,
                    output ready);
endinterface

interface rlps_result_if;
    logic                        valid;
    logic                        ready;
    logic [rlps_pkg::BYTE_W-1:0] compare_value;
    logic                        in_reset_gap;
    logic                        frame_last;

    modport source (output valid, compare_value, in_reset_gap, frame_last, input ready);
    modport sink   (input valid, compare_value, in_reset_gap, frame_last, output ready);
endinterface

interface rlps_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rlps_pkg::CFG_IDX_W-1:0]  index;
    logic [rlps_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hdl/rlps_cfg.sv */
`default_nettype none

module rlps_cfg (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rlps_cfg_if.sink    i_cfg,
    output rlps_pkg::t_cfg o_cfg
);

    logic [rlps_pkg::BYTE_W-1:0]  r_zero_high;
    logic [rlps_pkg::BYTE_W-1:0]  r_one_high;
    logic [rlps_pkg::POS_W-1:0]   r_eff_count;
    logic [rlps_pkg::GAP_W-1:0]   r_gap_len;
    logic [rlps_pkg::SHIFT_W-1:0] r_dim_shift;

    logic                           wr;
    logic [rlps_pkg::COUNT_W-1:0]   cnt_in;
    logic [rlps_pkg::GAP_W-1:0]     gap_in;

    assign i_cfg.ready = 1'b1;
    assign wr     = i_cfg.valid && i_cfg.ready;
    assign cnt_in = i_cfg.data[rlps_pkg::COUNT_W-1:0];
    assign gap_in = i_cfg.data[rlps_pkg::GAP_W-1:0];

    // count is clamped to capacity and a zero gap becomes one, both at write time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_high <= rlps_pkg::RST_ZERO_HIGH_TIME;
            r_one_high  <= rlps_pkg::RST_ONE_HIGH_TIME;
            r_eff_count <= rlps_pkg::POS_W'(rlps_pkg::RST_LED_COUNT);
            r_gap_len   <= rlps_pkg::RST_RESET_SLOTS;
            r_dim_shift <= rlps_pkg::RST_DIM_SHIFT;
        end else if (wr) begin
            unique case (i_cfg.index)
                rlps_pkg::CFG_ZERO_HIGH_TIME: begin
                    r_zero_high <= i_cfg.data[rlps_pkg::BYTE_W-1:0];
                end
                rlps_pkg::CFG_ONE_HIGH_TIME: begin
                    r_one_high <= i_cfg.data[rlps_pkg::BYTE_W-1:0];
                end
                rlps_pkg::CFG_LED_COUNT: begin
                    if (32'(cnt_in) > 32'(rlps_pkg::MAX_LEDS)) begin
                        r_eff_count <= rlps_pkg::POS_W'(rlps_pkg::MAX_LEDS);
                    end else begin
                        r_eff_count <= rlps_pkg::POS_W'(cnt_in);
                    end
                end
                rlps_pkg::CFG_RESET_SLOTS: begin
                    r_gap_len <= (gap_in == '0) ? rlps_pkg::GAP_W'(1) : gap_in;
                end
                rlps_pkg::CFG_DIM_SHIFT: begin
                    r_dim_shift <= i_cfg.data[rlps_pkg::SHIFT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.zero_high = r_zero_high;
    assign o_cfg.one_high  = r_one_high;
    assign o_cfg.eff_count = r_eff_count;
    assign o_cfg.gap_len   = r_gap_len;
    assign o_cfg.dim_shift = r_dim_shift;

endmodule

`default_nettype wire

/* hdl/rlps_seq.sv */
`default_nettype none

module rlps_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    rlps_item_if.sink          i_item,
    input  rlps_pkg::t_cfg     i_cfg,
    input  wire logic          i_clr_busy,
    input  wire logic          i_s2_ready,
    output rlps_pkg::t_mem_req o_req,
    output rlps_pkg::t_slot    o_slot
);

    // input register
    logic                             r_s1_valid;
    logic                             r_s1_op;
    logic [rlps_pkg::LED_INDEX_W-1:0] r_s1_idx;
    logic [rlps_pkg::BYTE_W-1:0]      r_s1_b0;
    logic [rlps_pkg::BYTE_W-1:0]      r_s1_b1;
    logic [rlps_pkg::BYTE_W-1:0]      r_s1_b2;

    // frame position
    logic [rlps_pkg::POS_W-1:0] r_pos, n_pos;
    logic [rlps_pkg::BIT_W-1:0] r_bit, n_bit;
    logic [rlps_pkg::GAP_W-1:0] r_gap_cnt, n_gap_cnt;
    logic                       r_in_gap, n_in_gap;

    logic                       is_tick;
    logic                       fire;
    logic                       accept;
    logic                       gap_now;
    logic                       slot_last;
    logic [rlps_pkg::GAP_W-1:0] gc_inc;
    logic [rlps_pkg::BIT_W-1:0] bit_inc;
    logic [rlps_pkg::POS_W-1:0] pos_inc;

    assign is_tick = (r_s1_op == rlps_pkg::OP_TICK);
    // a store never waits on the result side
    assign fire    = r_s1_valid && (!is_tick || i_s2_ready);
    assign i_item.ready = !i_clr_busy && (!r_s1_valid || fire);
    assign accept  = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op  <= i_item.op;
            r_s1_idx <= i_item.led_index;
            r_s1_b0  <= i_item.first_byte;
            r_s1_b1  <= i_item.second_byte;
            r_s1_b2  <= i_item.third_byte;
        end
    end

    always_comb begin
        gap_now   = r_in_gap || (r_pos >= i_cfg.eff_count);
        gc_inc    = (r_in_gap ? r_gap_cnt : '0) + rlps_pkg::GAP_W'(1);
        bit_inc   = r_bit + rlps_pkg::BIT_W'(1);
        pos_inc   = r_pos + rlps_pkg::POS_W'(1);
        n_pos     = r_pos;
        n_bit     = r_bit;
        n_gap_cnt = r_gap_cnt;
        n_in_gap  = r_in_gap;
        slot_last = 1'b0;
        if (gap_now) begin
            if (gc_inc >= i_cfg.gap_len) begin
                slot_last = 1'b1;
                n_in_gap  = 1'b0;
                n_gap_cnt = '0;
                n_pos     = '0;
                n_bit     = '0;
            end else begin
                n_in_gap  = 1'b1;
                n_gap_cnt = gc_inc;
            end
        end else if (bit_inc == rlps_pkg::BIT_W'(rlps_pkg::BITS_PER_LED)) begin
            n_bit = '0;
            n_pos = pos_inc;
            if (pos_inc >= i_cfg.eff_count) begin
                n_in_gap  = 1'b1;
                n_gap_cnt = '0;
            end
        end else begin
            n_bit = bit_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_bit     <= '0;
            r_gap_cnt <= '0;
            r_in_gap  <= 1'b0;
        end else if (fire && is_tick) begin
            r_pos     <= n_pos;
            r_bit     <= n_bit;
            r_gap_cnt <= n_gap_cnt;
            r_in_gap  <= n_in_gap;
        end
    end

    assign o_slot.valid = fire && is_tick;
    assign o_slot.gap   = gap_now;
    assign o_slot.last  = slot_last;
    assign o_slot.sh    = rlps_pkg::BIT_W'(rlps_pkg::BITS_PER_LED - 1) - r_bit;

    assign o_req.we    = fire && !is_tick && (32'(r_s1_idx) < 32'(i_cfg.eff_count));
    assign o_req.waddr = rlps_pkg::IDX_W'(r_s1_idx);
    assign o_req.wdata = {r_s1_b0 >> i_cfg.dim_shift,
                          r_s1_b1 >> i_cfg.dim_shift,
                          r_s1_b2 >> i_cfg.dim_shift};
    assign o_req.re    = fire && is_tick;
    assign o_req.raddr = r_pos[rlps_pkg::IDX_W-1:0];

`ifndef SYNTHESIS
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit < rlps_pkg::BIT_W'(rlps_pkg::BITS_PER_LED))
        else $error("bit position past last bit of led");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) <= 32'(rlps_pkg::MAX_LEDS))
        else $error("led position beyond capacity");
`endif

endmodule

`default_nettype wire

/* hdl/rlps_store.sv */
`default_nettype none

module rlps_store (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  rlps_pkg::t_mem_req               i_req,
    output logic                             o_busy,
    output logic [rlps_pkg::COLOR_W-1:0]     o_rd_data
);

    logic [rlps_pkg::COLOR_W-1:0] r_mem [rlps_pkg::MAX_LEDS];
    logic [rlps_pkg::COLOR_W-1:0] r_rd;
    logic                         r_clr_busy;
    logic [rlps_pkg::IDX_W-1:0]   r_clr_addr;

    // clearing pass after reset, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == rlps_pkg::IDX_W'(rlps_pkg::MAX_LEDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + rlps_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd <= r_mem[i_req.raddr];
        end
    end

    assign o_busy    = r_clr_busy;
    assign o_rd_data = r_rd;

`ifndef SYNTHESIS
    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_clr_busy && (i_req.we || i_req.re)))
        else $error("store access during clearing pass");
`endif

endmodule

`default_nettype wire

/* hdl/rlps_out.sv */
`default_nettype none

module rlps_out (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  rlps_pkg::t_slot              i_slot,
    input  wire logic [rlps_pkg::COLOR_W-1:0] i_rd_data,
    input  rlps_pkg::t_cfg               i_cfg,
    rlps_result_if.source                o_result,
    output logic                         o_s2_ready
);

    // stage 2: slot info waiting for the store read data
    logic                       r_s2_valid;
    logic                       r_s2_gap;
    logic                       r_s2_last;
    logic [rlps_pkg::BIT_W-1:0] r_s2_sh;

    // result register
    logic                        r_o_valid;
    logic [rlps_pkg::BYTE_W-1:0] r_o_cmp;
    logic                        r_o_gap;
    logic                        r_o_last;

    logic                        out_en;
    logic [rlps_pkg::BYTE_W-1:0] cmp;

    assign out_en     = !r_o_valid || o_result.ready;
    assign o_s2_ready = !r_s2_valid || out_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_s2_ready) begin
                r_s2_valid <= i_slot.valid;
            end
            if (out_en) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_slot.valid) begin
            r_s2_gap  <= i_slot.gap;
            r_s2_last <= i_slot.last;
            r_s2_sh   <= i_slot.sh;
        end
        if (r_s2_valid && out_en) begin
            r_o_cmp  <= cmp;
            r_o_gap  <= r_s2_gap;
            r_o_last <= r_s2_last;
        end
    end

    always_comb begin
        if (r_s2_gap) begin
            cmp = '0;
        end else if (i_rd_data[r_s2_sh]) begin
            cmp = i_cfg.one_high;
        end else begin
            cmp = i_cfg.zero_high;
        end
    end

    assign o_result.valid         = r_o_valid;
    assign o_result.compare_value = r_o_cmp;
    assign o_result.in_reset_gap  = r_o_gap;
    assign o_result.frame_last    = r_o_last;

`ifndef SYNTHESIS
    a_last_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_last) |-> r_o_gap)
        else $error("frame end outside latch gap");

    a_gap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_gap) |-> (r_o_cmp == '0))
        else $error("nonzero compare value in latch gap");
`endif

endmodule

`default_nettype wire

/* hdl/rgb_led_pulse_width_serializer_unit.sv */
`default_nettype none

// addressable rgb led pwm bit encoder
//
// i_item: store items (op 0) write three color bytes of one led, each shifted
// right by dim_shift; an index at or above the led count is dropped. tick items
// (op 1) each produce one result on o_result: the compare value of the next bit
// period, with flags for the latch gap and for the last slot of the frame.
// i_cfg: register writes, always ready; write only while no item is in flight.
// pipeline: a tick passes the input register, the store read and the result
// register in turn. one item per cycle sustained while not stalled or clearing;
// the store read and the bit select sit in separate stages.
// reset: registers take their reset values and the color store is swept to zero,
// one entry a cycle, so i_item.ready stays low until all 1024 entries are zero.
// stall: the result register holds while o_result.ready is low; ticks back up
// into stage 2 and the input register, stores pass until a tick waits in the
// input register, and from then i_item.ready is low until the result is taken.
module rgb_led_pulse_width_serializer_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    rlps_item_if.sink       i_item,
    rlps_cfg_if.sink        i_cfg,
    rlps_result_if.source   o_result
);

    rlps_pkg::t_cfg                cfg;
    rlps_pkg::t_mem_req            req;
    rlps_pkg::t_slot               slot;
    logic                          clr_busy;
    logic                          s2_ready;
    logic [rlps_pkg::COLOR_W-1:0]  rd_data;

    rlps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    rlps_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg      (cfg),
        .i_clr_busy (clr_busy),
        .i_s2_ready (s2_ready),
        .o_req      (req),
        .o_slot     (slot)
    );

    rlps_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_busy    (clr_busy),
        .o_rd_data (rd_data)
    );

    rlps_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_slot     (slot),
        .i_rd_data  (rd_data),
        .i_cfg      (cfg),
        .o_result   (o_result),
        .o_s2_ready (s2_ready)
    );

endmodule

`default_nettype wire
